/* hw/rtl/dfrt_pkg.sv */
`default_nettype none
package dfrt_pkg;

  localparam int TableEntries = 1024;
  localparam int KeyBits      = 64;
  localparam int FpW          = 64;
  localparam int AddrW        = $clog2(TableEntries);
  localparam int PtrW         = $clog2(TableEntries + 1);
  localparam int CntW         = 32;
  localparam int LimitW       = 11;
  localparam int CmpW         = (PtrW > LimitW) ? PtrW : LimitW;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 32;

  localparam logic [CfgIdxW-1:0] RegDupThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegEntryLimit   = CfgIdxW'(1);

  localparam logic [CntW-1:0]   ThrReset   = '1;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(1024);

  typedef enum logic [1:0] {
    ModeClear,
    ModeScan,
    ModeFlush
  } sweep_mode_e;

  typedef struct packed {
    logic        load_key;
    logic        sweep_start;
    logic        sweep_run;
    sweep_mode_e mode;
    logic        occ_load;
    logic        do_update;
    logic        do_insert;
    logic        do_drop;
    logic        set_flushed;
    logic        publish;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic hit;
    logic full;
  } dp_sts_t;

  typedef struct packed {
    logic               valid;
    logic               over;
    logic [CntW-1:0]    count;
    logic [KeyBits-1:0] key;
  } entry_t;

endpackage
`default_nettype wire

/* hw/rtl/dfrt_dp.sv */
`default_nettype none
module dfrt_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dfrt_pkg::dp_cmd_t             cmd_i,
  output dfrt_pkg::dp_sts_t                  sts_o,
  input  wire logic [dfrt_pkg::FpW-1:0]      fingerprint_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [dfrt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dfrt_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                               was_present_o,
  output logic                               redundant_o,
  output logic                               dropped_o,
  output logic                               flushed_o
);

  localparam logic [dfrt_pkg::PtrW-1:0] PtrMax = dfrt_pkg::PtrW'(dfrt_pkg::TableEntries);
  localparam logic [dfrt_pkg::CmpW-1:0] CapCmp = dfrt_pkg::CmpW'(dfrt_pkg::TableEntries);

  dfrt_pkg::entry_t mem [dfrt_pkg::TableEntries];

  logic [dfrt_pkg::PtrW-1:0]    ptr_q;
  logic                         p_vld_q;
  logic [dfrt_pkg::AddrW-1:0]   p_idx_q;
  dfrt_pkg::entry_t             rdata_q;
  logic [dfrt_pkg::KeyBits-1:0] key_q;
  logic                         hit_q;
  logic [dfrt_pkg::AddrW-1:0]   hit_idx_q;
  dfrt_pkg::entry_t             hit_ent_q;
  logic                         free_found_q;
  logic [dfrt_pkg::AddrW-1:0]   free_idx_q;
  logic [dfrt_pkg::PtrW-1:0]    occ_q;
  logic [dfrt_pkg::PtrW-1:0]    occ_cnt_q;
  logic [dfrt_pkg::CntW-1:0]    thr_q;
  logic [dfrt_pkg::LimitW-1:0]  lim_q;
  logic                         st_present_q, st_red_q, st_drop_q, st_flush_q;
  logic                         out_present_q, out_red_q, out_drop_q, out_flush_q;

  logic                         issue, re, we;
  logic [dfrt_pkg::AddrW-1:0]   waddr;
  dfrt_pkg::entry_t             wdata;
  logic [dfrt_pkg::CntW-1:0]    cnt_new;
  logic                         over_new;
  logic                         ins_over;
  logic [dfrt_pkg::CmpW-1:0]    lim_cmp, lim_eff;
  logic                         proc;

  assign issue    = cmd_i.sweep_run && (ptr_q < PtrMax);
  assign re       = issue && (cmd_i.mode != dfrt_pkg::ModeClear);
  assign proc     = cmd_i.sweep_run && p_vld_q;
  assign cnt_new  = (hit_ent_q.count == '1) ? hit_ent_q.count
                                            : hit_ent_q.count + dfrt_pkg::CntW'(1);
  assign over_new = hit_ent_q.over || (cnt_new >= thr_q);
  assign ins_over = (dfrt_pkg::CntW'(1) >= thr_q);
  assign lim_cmp  = dfrt_pkg::CmpW'(lim_q);
  assign lim_eff  = (lim_cmp > CapCmp) ? CapCmp : lim_cmp;

  assign sts_o.sweep_done = (ptr_q == PtrMax) && !p_vld_q;
  assign sts_o.hit        = hit_q;
  assign sts_o.full       = (dfrt_pkg::CmpW'(occ_q) >= lim_eff);

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q[dfrt_pkg::AddrW-1:0];
    wdata = '0;
    if (cmd_i.mode == dfrt_pkg::ModeClear && issue) begin
      we = 1'b1;
    end else if (cmd_i.mode == dfrt_pkg::ModeFlush && proc && rdata_q.valid
                 && !rdata_q.over) begin
      we    = 1'b1;
      waddr = p_idx_q;
    end else if (cmd_i.do_update) begin
      we          = 1'b1;
      waddr       = hit_idx_q;
      wdata.valid = 1'b1;
      wdata.over  = over_new;
      wdata.count = cnt_new;
      wdata.key   = key_q;
    end else if (cmd_i.do_insert) begin
      we          = 1'b1;
      waddr       = free_idx_q;
      wdata.valid = 1'b1;
      wdata.over  = ins_over;
      wdata.count = dfrt_pkg::CntW'(1);
      wdata.key   = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[ptr_q[dfrt_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= fingerprint_i[dfrt_pkg::KeyBits-1:0];
    end
    if (issue) begin
      p_idx_q <= ptr_q[dfrt_pkg::AddrW-1:0];
    end
    if (cmd_i.mode == dfrt_pkg::ModeScan && proc && rdata_q.valid
        && rdata_q.key == key_q) begin
      hit_idx_q <= p_idx_q;
      hit_ent_q <= rdata_q;
    end
    if (proc && !free_found_q && !(rdata_q.valid
        && (cmd_i.mode == dfrt_pkg::ModeScan || rdata_q.over))) begin
      free_idx_q <= p_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      p_vld_q       <= 1'b0;
      hit_q         <= 1'b0;
      free_found_q  <= 1'b0;
      occ_q         <= '0;
      occ_cnt_q     <= '0;
      thr_q         <= dfrt_pkg::ThrReset;
      lim_q         <= dfrt_pkg::LimitReset;
      st_present_q  <= 1'b0;
      st_red_q      <= 1'b0;
      st_drop_q     <= 1'b0;
      st_flush_q    <= 1'b0;
      out_present_q <= 1'b0;
      out_red_q     <= 1'b0;
      out_drop_q    <= 1'b0;
      out_flush_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dfrt_pkg::RegDupThreshold: thr_q <= cfg_data_i;
          dfrt_pkg::RegEntryLimit:   lim_q <= cfg_data_i[dfrt_pkg::LimitW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.sweep_start) begin
        ptr_q        <= '0;
        p_vld_q      <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        occ_cnt_q    <= '0;
      end else begin
        if (issue) begin
          ptr_q <= ptr_q + dfrt_pkg::PtrW'(1);
        end
        p_vld_q <= re;
        if (cmd_i.mode == dfrt_pkg::ModeScan && proc && rdata_q.valid
            && rdata_q.key == key_q) begin
          hit_q <= 1'b1;
        end
        if (proc && !(rdata_q.valid
            && (cmd_i.mode == dfrt_pkg::ModeScan || rdata_q.over))) begin
          free_found_q <= 1'b1;
        end
        if (cmd_i.mode == dfrt_pkg::ModeFlush && proc && rdata_q.valid
            && rdata_q.over) begin
          occ_cnt_q <= occ_cnt_q + dfrt_pkg::PtrW'(1);
        end
      end
      if (cmd_i.occ_load) begin
        occ_q <= occ_cnt_q;
      end else if (cmd_i.do_insert) begin
        occ_q <= occ_q + dfrt_pkg::PtrW'(1);
      end
      if (cmd_i.load_key) begin
        st_flush_q <= 1'b0;
      end else if (cmd_i.set_flushed) begin
        st_flush_q <= 1'b1;
      end
      if (cmd_i.do_update) begin
        st_present_q <= 1'b1;
        st_red_q     <= over_new;
        st_drop_q    <= 1'b0;
      end else if (cmd_i.do_insert) begin
        st_present_q <= 1'b0;
        st_red_q     <= ins_over;
        st_drop_q    <= 1'b0;
      end else if (cmd_i.do_drop) begin
        st_present_q <= 1'b0;
        st_red_q     <= 1'b0;
        st_drop_q    <= 1'b1;
      end
      if (cmd_i.publish) begin
        out_present_q <= st_present_q;
        out_red_q     <= st_red_q;
        out_drop_q    <= st_drop_q;
        out_flush_q   <= st_flush_q;
      end
    end
  end

  assign was_present_o = out_present_q;
  assign redundant_o   = out_red_q;
  assign dropped_o     = out_drop_q;
  assign flushed_o     = out_flush_q;

  a_occ_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= PtrMax) else $error("occupancy above capacity");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.do_update && cmd_i.do_insert)) else $error("update and insert together");
  a_ins_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_insert |-> free_found_q) else $error("insert without free slot");

endmodule
`default_nettype wire

/* hw/rtl/dfrt_ctrl.sv */
`default_nettype none
module dfrt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dfrt_pkg::dp_cmd_t      cmd_o,
  input  wire dfrt_pkg::dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_FSTART, S_FLUSH, S_CHECK, S_UPD, S_INS, S_DROP, S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   can_pub;

  assign can_pub     = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.mode = dfrt_pkg::ModeScan;
    state_d    = state_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.mode      = dfrt_pkg::ModeClear;
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_key    = 1'b1;
          cmd_o.sweep_start = 1'b1;
          state_d           = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          state_d = S_UPD;
        end else if (sts_i.sweep_done) begin
          state_d = sts_i.full ? S_FSTART : S_INS;
        end else begin
          cmd_o.sweep_run = 1'b1;
        end
      end
      S_FSTART: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.set_flushed = 1'b1;
        state_d           = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.mode = dfrt_pkg::ModeFlush;
        if (sts_i.sweep_done) begin
          cmd_o.occ_load = 1'b1;
          state_d        = S_CHECK;
        end else begin
          cmd_o.sweep_run = 1'b1;
        end
      end
      S_CHECK: state_d = sts_i.full ? S_DROP : S_INS;
      S_UPD: begin
        cmd_o.do_update = 1'b1;
        state_d         = S_RESP;
      end
      S_INS: begin
        cmd_o.do_insert = 1'b1;
        state_d         = S_RESP;
      end
      S_DROP: begin
        cmd_o.do_drop = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (can_pub) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_RESP && can_pub) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> can_pub) else $error("result overwritten");
  a_no_accept_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !in_ready_o) else $error("accept during clear");
  a_upd_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $past(sts_i.hit)) else $error("update without hit");

endmodule
`default_nettype wire

/* hw/rtl/dedup_fingerprint_refcount_table.sv */
// Fingerprint reference-count table for deduplication. Each input word is a
// 64-bit key; the result word reports was_present, redundant, dropped and
// flushed. Keys live in a 1024-entry memory that is scanned one entry per
// cycle, and a hit ends the scan early; a key that finds the table full adds
// a flush sweep over the table. After reset a clearing pass runs before the
// first word is taken (configuration writes are taken at any time). One word
// is processed at a time; a finished result may wait in the output register
// while the next word is accepted. cfg index 0 is dup_threshold, 1 is
// entry_limit.
`default_nettype none
module dedup_fingerprint_refcount_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dfrt_pkg::FpW-1:0]      fingerprint_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               was_present_o,
  output logic                               redundant_o,
  output logic                               dropped_o,
  output logic                               flushed_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dfrt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dfrt_pkg::CfgDataW-1:0] cfg_data_i
);

  dfrt_pkg::dp_cmd_t cmd;
  dfrt_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dfrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dfrt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .fingerprint_i (fingerprint_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .was_present_o (was_present_o),
    .redundant_o   (redundant_o),
    .dropped_o     (dropped_o),
    .flushed_o     (flushed_o)
  );

endmodule
`default_nettype wire
